### hw/rtl/cllm_pkg.sv
// shared types and constants of the cursor linked list manager
`timescale 1ns / 1ps
package cllm_pkg;

   localparam int NODES  = 128;
   localparam int IDX_W  = 7;
   localparam int STEP_W = $clog2(NODES) + 1;

   // operation codes
   localparam logic [2:0] OP_READ        = 3'd0;
   localparam logic [2:0] OP_FIND        = 3'd1;
   localparam logic [2:0] OP_INSERT      = 3'd2;
   localparam logic [2:0] OP_DELETE      = 3'd3;
   localparam logic [2:0] OP_MAKE_EMPTY  = 3'd4;
   localparam logic [2:0] OP_DELETE_LIST = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // read address select
   localparam logic [1:0] RA_ZERO = 2'd0;
   localparam logic [1:0] RA_HEAD = 2'd1;
   localparam logic [1:0] RA_POS  = 2'd2;
   localparam logic [1:0] RA_LQ   = 2'd3;

   // write address select
   localparam logic [2:0] WA_PRV   = 3'd0;
   localparam logic [2:0] WA_T     = 3'd1;
   localparam logic [2:0] WA_CUR   = 3'd2;
   localparam logic [2:0] WA_ZERO  = 3'd3;
   localparam logic [2:0] WA_AUX   = 3'd4;
   localparam logic [2:0] WA_POS   = 3'd5;
   localparam logic [2:0] WA_HEAD  = 3'd6;
   localparam logic [2:0] WA_STEPS = 3'd7;

   // write data select
   localparam logic [2:0] WD_LQ    = 3'd0;
   localparam logic [2:0] WD_CUR   = 3'd1;
   localparam logic [2:0] WD_ZERO  = 3'd2;
   localparam logic [2:0] WD_AUX   = 3'd3;
   localparam logic [2:0] WD_HEAD  = 3'd4;
   localparam logic [2:0] WD_STEPS = 3'd5;

   // tail pointer source
   localparam logic [1:0] TS_LQ   = 2'd0;
   localparam logic [1:0] TS_ZERO = 2'd1;
   localparam logic [1:0] TS_HEAD = 2'd2;

   // response index select
   localparam logic [1:0] IX_ZERO = 2'd0;
   localparam logic [1:0] IX_POS  = 2'd1;
   localparam logic [1:0] IX_CUR  = 2'd2;
   localparam logic [1:0] IX_AUX  = 2'd3;

   typedef struct packed {
      logic       ld_req;
      logic [1:0] ra_sel;
      logic       wr_en;
      logic [2:0] wa_sel;
      logic [2:0] wd_sel;
      logic       val_wr;
      logic       st_clr;
      logic       st_inc;
      logic       cur_ld;
      logic       prv_head;
      logic       prv_cur;
      logic       t_ld;
      logic [1:0] t_src;
      logic       aux_ld;
      logic       rsp_en;
      logic [1:0] rsp_idx;
      logic       rsp_read;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       head_zero;
      logic       lq_zero;
      logic       val_match;
      logic       steps_last;
      logic       steps_max;
   } sts_type;

endpackage

### hw/rtl/cllm_dpath.sv
// datapath: node stores, walk registers and response registers
`timescale 1ns / 1ps
module cllm_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  cllm_pkg::cmd_type            cmd,
   output cllm_pkg::sts_type            sts,
   input  logic [2:0]                   req_operation,
   input  logic [cllm_pkg::IDX_W-1:0]   req_list_head,
   input  logic [cllm_pkg::IDX_W-1:0]   req_position,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_strobe,
   output logic [cllm_pkg::IDX_W-1:0]   rsp_node_index,
   output logic signed [31:0]           rsp_node_value,
   output logic [cllm_pkg::IDX_W-1:0]   rsp_next_index,
   output logic [1:0]                   rsp_status
);

   logic [cllm_pkg::IDX_W-1:0] link_mem [cllm_pkg::NODES];
   logic signed [31:0]         value_mem [cllm_pkg::NODES];

   logic [2:0]                  op_ff;
   logic [cllm_pkg::IDX_W-1:0]  head_ff, pos_ff, cur_ff, prv_ff, t_ff, aux_ff, lq_ff;
   logic signed [31:0]          val_ff, vq_ff;
   logic [cllm_pkg::STEP_W-1:0] steps_ff, steps_in;

   logic                        strobe_ff;
   logic [cllm_pkg::IDX_W-1:0]  ridx_ff, rnext_ff;
   logic signed [31:0]          rval_ff;
   logic [1:0]                  rst_ff;

   logic [cllm_pkg::IDX_W-1:0]  raddr, waddr, wdata, cnt_idx, cnt_next, ridx_in;

   // address and data selection
   always_comb begin
      cnt_idx  = steps_ff[cllm_pkg::IDX_W-1:0];
      cnt_next = sts.steps_last ? '0 : cnt_idx + 1'b1;
      case (cmd.ra_sel)
         cllm_pkg::RA_ZERO: raddr = '0;
         cllm_pkg::RA_HEAD: raddr = head_ff;
         cllm_pkg::RA_POS:  raddr = pos_ff;
         default:           raddr = lq_ff;
      endcase
      case (cmd.wa_sel)
         cllm_pkg::WA_PRV:  waddr = prv_ff;
         cllm_pkg::WA_T:    waddr = t_ff;
         cllm_pkg::WA_CUR:  waddr = cur_ff;
         cllm_pkg::WA_ZERO: waddr = '0;
         cllm_pkg::WA_AUX:  waddr = aux_ff;
         cllm_pkg::WA_POS:  waddr = pos_ff;
         cllm_pkg::WA_HEAD: waddr = head_ff;
         default:           waddr = cnt_idx;
      endcase
      case (cmd.wd_sel)
         cllm_pkg::WD_LQ:    wdata = lq_ff;
         cllm_pkg::WD_CUR:   wdata = cur_ff;
         cllm_pkg::WD_ZERO:  wdata = '0;
         cllm_pkg::WD_AUX:   wdata = aux_ff;
         cllm_pkg::WD_HEAD:  wdata = head_ff;
         cllm_pkg::WD_STEPS: wdata = cnt_next;
         default:            wdata = '0;
      endcase
      case (cmd.rsp_idx)
         cllm_pkg::IX_POS: ridx_in = pos_ff;
         cllm_pkg::IX_CUR: ridx_in = cur_ff;
         cllm_pkg::IX_AUX: ridx_in = aux_ff;
         default:          ridx_in = '0;
      endcase
      if (cmd.st_clr) begin
         steps_in = '0;
      end else if (cmd.st_inc) begin
         steps_in = steps_ff + 1'b1;
      end else begin
         steps_in = steps_ff;
      end
   end

   // status toward the controller
   always_comb begin
      sts.op         = op_ff;
      sts.head_zero  = (head_ff == '0);
      sts.lq_zero    = (lq_ff == '0);
      sts.val_match  = (vq_ff == val_ff);
      sts.steps_last = (steps_ff == cllm_pkg::STEP_W'(cllm_pkg::NODES - 1));
      sts.steps_max  = (steps_ff == cllm_pkg::STEP_W'(cllm_pkg::NODES));
   end

   // node stores, one read and one write per cycle
   always_ff @(posedge clock) begin
      lq_ff <= link_mem[raddr];
      vq_ff <= value_mem[raddr];
      if (cmd.wr_en) begin
         link_mem[waddr] <= wdata;
      end
      if (cmd.val_wr) begin
         value_mem[aux_ff] <= val_ff;
      end
   end

   // transaction and walk registers
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         op_ff   <= req_operation;
         head_ff <= req_list_head;
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.cur_ld) begin
         cur_ff <= lq_ff;
      end
      if (cmd.prv_head) begin
         prv_ff <= head_ff;
      end else if (cmd.prv_cur) begin
         prv_ff <= cur_ff;
      end
      if (cmd.t_ld) begin
         case (cmd.t_src)
            cllm_pkg::TS_ZERO: t_ff <= '0;
            cllm_pkg::TS_HEAD: t_ff <= head_ff;
            default:           t_ff <= lq_ff;
         endcase
      end
      if (cmd.aux_ld) begin
         aux_ff <= lq_ff;
      end
      if (cmd.rsp_en) begin
         ridx_ff  <= ridx_in;
         rval_ff  <= cmd.rsp_read ? vq_ff : '0;
         rnext_ff <= cmd.rsp_read ? lq_ff : '0;
         rst_ff   <= cmd.rsp_status;
      end
   end

   // step counter and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         steps_ff  <= steps_in;
         strobe_ff <= cmd.rsp_en;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_node_index = ridx_ff;
   assign rsp_node_value = rval_ff;
   assign rsp_next_index = rnext_ff;
   assign rsp_status     = rst_ff;

endmodule

### hw/rtl/cllm_ctrl.sv
// controller: sequences every operation as memory reads and writes
`timescale 1ns / 1ps
module cllm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cllm_pkg::sts_type sts,
   output cllm_pkg::cmd_type cmd
);

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_DISP = 5'd2;
   localparam logic [4:0] S_RDR  = 5'd3;
   localparam logic [4:0] S_W1   = 5'd4;
   localparam logic [4:0] S_W2   = 5'd5;
   localparam logic [4:0] S_D0   = 5'd6;
   localparam logic [4:0] S_D1   = 5'd7;
   localparam logic [4:0] S_TL   = 5'd8;
   localparam logic [4:0] S_FD   = 5'd9;
   localparam logic [4:0] S_I1   = 5'd10;
   localparam logic [4:0] S_I2   = 5'd11;
   localparam logic [4:0] S_I3   = 5'd12;
   localparam logic [4:0] S_I4   = 5'd13;
   localparam logic [4:0] S_I5   = 5'd14;
   localparam logic [4:0] S_ME   = 5'd15;
   localparam logic [4:0] S_ME2  = 5'd16;
   localparam logic [4:0] S_DL   = 5'd17;
   localparam logic [4:0] S_DL2  = 5'd18;

   logic [4:0] state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_STEPS;
            cmd.wd_sel = cllm_pkg::WD_STEPS;
            cmd.st_inc = 1'b1;
            if (sts.steps_last) begin
               cmd.st_clr = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.op)
               cllm_pkg::OP_READ: begin
                  cmd.ra_sel = cllm_pkg::RA_POS;
                  state_in   = S_RDR;
               end
               cllm_pkg::OP_FIND, cllm_pkg::OP_DELETE: begin
                  cmd.ra_sel   = cllm_pkg::RA_HEAD;
                  cmd.prv_head = 1'b1;
                  cmd.st_clr   = 1'b1;
                  state_in     = S_W1;
               end
               cllm_pkg::OP_INSERT: begin
                  cmd.ra_sel = cllm_pkg::RA_ZERO;
                  state_in   = S_I1;
               end
               cllm_pkg::OP_MAKE_EMPTY: begin
                  if (sts.head_zero) begin
                     cmd.rsp_en = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.ra_sel = cllm_pkg::RA_ZERO;
                     cmd.t_ld   = 1'b1;
                     cmd.t_src  = cllm_pkg::TS_ZERO;
                     cmd.st_clr = 1'b1;
                     state_in   = S_TL;
                  end
               end
               cllm_pkg::OP_DELETE_LIST: begin
                  if (sts.head_zero) begin
                     cmd.rsp_en = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.ra_sel = cllm_pkg::RA_HEAD;
                     cmd.t_ld   = 1'b1;
                     cmd.t_src  = cllm_pkg::TS_HEAD;
                     cmd.st_clr = 1'b1;
                     state_in   = S_TL;
                  end
               end
               default: begin
                  cmd.rsp_en = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_RDR: begin
            cmd.rsp_en   = 1'b1;
            cmd.rsp_idx  = cllm_pkg::IX_POS;
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         // first link after the header
         S_W1: begin
            if (sts.lq_zero) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = cllm_pkg::ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.cur_ld = 1'b1;
               cmd.ra_sel = cllm_pkg::RA_LQ;
               state_in   = S_W2;
            end
         end
         // compare one node per step
         S_W2: begin
            if (sts.val_match) begin
               if (sts.op == cllm_pkg::OP_FIND) begin
                  cmd.rsp_en  = 1'b1;
                  cmd.rsp_idx = cllm_pkg::IX_CUR;
                  state_in    = S_IDLE;
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wa_sel = cllm_pkg::WA_PRV;
                  cmd.wd_sel = cllm_pkg::WD_LQ;
                  state_in   = S_D0;
               end
            end else if (sts.lq_zero || sts.steps_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = cllm_pkg::ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.prv_cur = 1'b1;
               cmd.cur_ld  = 1'b1;
               cmd.st_inc  = 1'b1;
               cmd.ra_sel  = cllm_pkg::RA_LQ;
            end
         end
         S_D0: begin
            cmd.ra_sel = cllm_pkg::RA_ZERO;
            state_in   = S_D1;
         end
         S_D1: begin
            cmd.t_ld   = 1'b1;
            cmd.t_src  = cllm_pkg::TS_LQ;
            cmd.st_clr = 1'b1;
            cmd.ra_sel = cllm_pkg::RA_LQ;
            state_in   = S_TL;
         end
         // tail search, one link per step
         S_TL: begin
            if (!sts.lq_zero && !sts.steps_max) begin
               cmd.t_ld   = 1'b1;
               cmd.t_src  = cllm_pkg::TS_LQ;
               cmd.st_inc = 1'b1;
               cmd.ra_sel = cllm_pkg::RA_LQ;
            end else if (sts.op == cllm_pkg::OP_DELETE) begin
               cmd.wr_en  = 1'b1;
               cmd.wa_sel = cllm_pkg::WA_T;
               cmd.wd_sel = cllm_pkg::WD_CUR;
               state_in   = S_FD;
            end else if (sts.op == cllm_pkg::OP_MAKE_EMPTY) begin
               cmd.ra_sel = cllm_pkg::RA_HEAD;
               state_in   = S_ME;
            end else begin
               cmd.ra_sel = cllm_pkg::RA_ZERO;
               state_in   = S_DL;
            end
         end
         S_FD: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = cllm_pkg::WA_CUR;
            cmd.wd_sel  = cllm_pkg::WD_ZERO;
            cmd.rsp_en  = 1'b1;
            cmd.rsp_idx = cllm_pkg::IX_CUR;
            state_in    = S_IDLE;
         end
         // insert: free head arrives
         S_I1: begin
            if (sts.lq_zero) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = cllm_pkg::ST_FULL;
               state_in       = S_IDLE;
            end else begin
               cmd.aux_ld = 1'b1;
               cmd.ra_sel = cllm_pkg::RA_LQ;
               state_in   = S_I2;
            end
         end
         S_I2: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_ZERO;
            cmd.wd_sel = cllm_pkg::WD_LQ;
            state_in   = S_I3;
         end
         S_I3: begin
            cmd.ra_sel = cllm_pkg::RA_POS;
            state_in   = S_I4;
         end
         S_I4: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_AUX;
            cmd.wd_sel = cllm_pkg::WD_LQ;
            state_in   = S_I5;
         end
         S_I5: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = cllm_pkg::WA_POS;
            cmd.wd_sel  = cllm_pkg::WD_AUX;
            cmd.val_wr  = 1'b1;
            cmd.rsp_en  = 1'b1;
            cmd.rsp_idx = cllm_pkg::IX_AUX;
            state_in    = S_IDLE;
         end
         S_ME: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_T;
            cmd.wd_sel = cllm_pkg::WD_LQ;
            state_in   = S_ME2;
         end
         S_ME2: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_HEAD;
            cmd.wd_sel = cllm_pkg::WD_ZERO;
            cmd.rsp_en = 1'b1;
            state_in   = S_IDLE;
         end
         S_DL: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_T;
            cmd.wd_sel = cllm_pkg::WD_LQ;
            state_in   = S_DL2;
         end
         S_DL2: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = cllm_pkg::WA_ZERO;
            cmd.wd_sel = cllm_pkg::WD_HEAD;
            cmd.rsp_en = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a response always returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_en |=> (state_ff == S_IDLE))
      else $error("response not followed by idle");

   // no store write while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!cmd.wr_en && !cmd.val_wr))
      else $error("store written while idle");

endmodule

### hw/rtl/cursor_linked_list_manager_unit.sv
// top level of the cursor linked list manager
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | start, busy            | req_operation, req_list_head,
//            |                        | req_position, req_value
//   response | rsp_strobe (one cycle) | rsp_node_index, rsp_node_value,
//            |                        | rsp_next_index, rsp_status
//
// one memory read per cycle sets the pace: find walks the list, delete adds a walk
// of the free list, and make_empty and delete_list walk one chain.
// after reset the link store is swept with busy high, linking each node to the
// next and the last one to zero.
// the response strobe is registered from the last step and comes in the cycle
// after it; the receiver cannot stall it, and busy drops in that same cycle.
`timescale 1ns / 1ps
module cursor_linked_list_manager_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_operation,
   input  logic [cllm_pkg::IDX_W-1:0]   req_list_head,
   input  logic [cllm_pkg::IDX_W-1:0]   req_position,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_strobe,
   output logic [cllm_pkg::IDX_W-1:0]   rsp_node_index,
   output logic signed [31:0]           rsp_node_value,
   output logic [cllm_pkg::IDX_W-1:0]   rsp_next_index,
   output logic [1:0]                   rsp_status
);

   cllm_pkg::cmd_type cmd;
   cllm_pkg::sts_type sts;

   // sequencer
   cllm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // stores and registers
   cllm_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_list_head  (req_list_head),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_node_index (rsp_node_index),
      .rsp_node_value (rsp_node_value),
      .rsp_next_index (rsp_next_index),
      .rsp_status     (rsp_status)
   );

endmodule

### tb/tb.sv
// testbench of the cursor linked list manager: directed table, then random list traffic
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG = 5000;
   localparam int RANDOM_ITEMS = 1600;

   typedef struct {
      logic [2:0]  op;
      logic [6:0]  head;
      logic [6:0]  pos;
      logic [31:0] val;
   } list_cmd_type;

   typedef struct {
      logic [6:0]  idx;
      logic [31:0] nval;
      logic [6:0]  next;
      logic [1:0]  st;
   } list_rsp_type;

   typedef struct {
      list_cmd_type c;
      bit           typed;
      list_rsp_type r;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic [6:0]  req_list_head;
   logic [6:0]  req_position;
   logic [31:0] req_value;
   logic        rsp_strobe;
   logic [6:0]  rsp_node_index;
   logic [31:0] rsp_node_value;
   logic [6:0]  rsp_next_index;
   logic [1:0]  rsp_status;

   // shadow pool of the block
   logic [6:0]  link_mem [cllm_pkg::NODES];
   logic [31:0] value_mem [cllm_pkg::NODES];
   bit          value_set [cllm_pkg::NODES];

   list_rsp_type pending_q [$];
   list_rsp_type oldest;
   int           errors = 0;
   int           idle_cycles = 0;
   bit           burst_mode = 0;

   cursor_linked_list_manager_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_list_head(req_list_head),
      .req_position(req_position), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_node_index(rsp_node_index),
      .rsp_node_value(rsp_node_value), .rsp_next_index(rsp_next_index),
      .rsp_status(rsp_status)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   // walk to the end of a chain, at most NODES links
   function automatic logic [6:0] chain_tail(input logic [6:0] from);
      logic [6:0] t;
      int steps;
      t = from;
      steps = 0;
      while (link_mem[t] != 0 && steps < cllm_pkg::NODES) begin
         t = link_mem[t];
         steps++;
      end
      return t;
   endfunction

   // true when the operation reads no value that was never written
   function automatic bit reads_written_only(input list_cmd_type c);
      logic [6:0] cur;
      int steps;
      if (c.op == cllm_pkg::OP_READ) return value_set[c.pos];
      if (c.op != cllm_pkg::OP_FIND && c.op != cllm_pkg::OP_DELETE) return 1;
      cur = link_mem[c.head];
      steps = 0;
      while (cur != 0 && steps < cllm_pkg::NODES) begin
         if (!value_set[cur]) return 0;
         if (value_mem[cur] == c.val) return 1;
         cur = link_mem[cur];
         steps++;
      end
      return 1;
   endfunction

   // apply one list operation to the shadow pool and give its response
   task automatic apply_list_op(input list_cmd_type c, output list_rsp_type r);
      logic [6:0] prev, cur, t, f;
      int steps;
      bit found;
      r = '{default: '0};
      r.st = cllm_pkg::ST_OK;
      case (c.op)
         cllm_pkg::OP_READ: begin
            r.idx = c.pos;
            r.nval = value_mem[c.pos];
            r.next = link_mem[c.pos];
         end
         cllm_pkg::OP_FIND, cllm_pkg::OP_DELETE: begin
            prev = c.head;
            cur = link_mem[c.head];
            steps = 0;
            found = 0;
            while (cur != 0 && steps < cllm_pkg::NODES && !found) begin
               if (value_mem[cur] == c.val) found = 1;
               else begin
                  prev = cur;
                  cur = link_mem[cur];
                  steps++;
               end
            end
            if (!found) r.st = cllm_pkg::ST_NOT_FOUND;
            else begin
               r.idx = cur;
               if (c.op == cllm_pkg::OP_DELETE) begin
                  link_mem[prev] = link_mem[cur];
                  t = chain_tail(link_mem[0]);
                  link_mem[t] = cur;
                  link_mem[cur] = 0;
               end
            end
         end
         cllm_pkg::OP_INSERT: begin
            f = link_mem[0];
            if (f == 0) r.st = cllm_pkg::ST_FULL;
            else begin
               link_mem[0] = link_mem[f];
               link_mem[f] = link_mem[c.pos];
               link_mem[c.pos] = f;
               value_mem[f] = c.val;
               value_set[f] = 1;
               r.idx = f;
            end
         end
         cllm_pkg::OP_MAKE_EMPTY: begin
            if (c.head != 0) begin
               t = chain_tail(0);
               link_mem[t] = link_mem[c.head];
               link_mem[c.head] = 0;
            end
         end
         cllm_pkg::OP_DELETE_LIST: begin
            if (c.head != 0) begin
               t = chain_tail(c.head);
               link_mem[t] = link_mem[0];
               link_mem[0] = c.head;
            end
         end
         default: ;
      endcase
   endtask

   // pick a written node of the chain after a header, with its value
   task automatic pick_from_list(input logic [6:0] h, output bit ok,
                                 output logic [6:0] node, output logic [31:0] v);
      logic [6:0] seen [$];
      logic [6:0] cur;
      int steps;
      cur = link_mem[h];
      steps = 0;
      while (cur != 0 && steps < cllm_pkg::NODES) begin
         if (value_set[cur]) seen.push_back(cur);
         cur = link_mem[cur];
         steps++;
      end
      ok = seen.size() != 0;
      node = ok ? seen[$urandom_range(0, seen.size() - 1)] : h;
      v = value_mem[node];
   endtask

   // drive one transaction and record what it should answer
   task automatic issue(input list_cmd_type c, input bit typed, input list_rsp_type want,
                        output list_rsp_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      req_operation = c.op;
      req_list_head = c.head;
      req_position = c.pos;
      req_value = c.val;
      start = 1;
      do @(posedge clock); while (busy);
      apply_list_op(c, r);
      pending_q.push_back(typed ? want : r);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic stim_row_type row(input logic [2:0] op, input logic [6:0] head,
                                        input logic [6:0] pos, input logic [31:0] val,
                                        input bit typed = 0, input logic [6:0] idx = 0,
                                        input logic [31:0] nval = 0,
                                        input logic [6:0] next = 0,
                                        input logic [1:0] st = cllm_pkg::ST_OK);
      stim_row_type s;
      s.c = '{op, head, pos, val};
      s.typed = typed;
      s.r = '{idx, nval, next, st};
      return s;
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_q.size() == 0)
            report("response with nothing pending", 32'(rsp_status), 32'd0);
         else begin
            oldest = pending_q.pop_front();
            if (rsp_node_index !== oldest.idx)
               report("node_index", 32'(rsp_node_index), 32'(oldest.idx));
            if (rsp_node_value !== oldest.nval)
               report("node_value", rsp_node_value, oldest.nval);
            if (rsp_next_index !== oldest.next)
               report("next_index", 32'(rsp_next_index), 32'(oldest.next));
            if (rsp_status !== oldest.st)
               report("status", 32'(rsp_status), 32'(oldest.st));
         end
      end
   end

   // watchdog on cycles with no transaction either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type table_rows [$];
      logic [6:0]   hdrs [$];
      list_cmd_type c;
      list_rsp_type r;
      logic [6:0]   h, node;
      logic [31:0]  v;
      bit ok;
      int sent, k, n;
      int next_drain, next_mode;

      start = 0;
      reset = 1;
      req_operation = cllm_pkg::OP_READ;
      req_list_head = 0;
      req_position = 0;
      req_value = 0;
      for (int i = 0; i < cllm_pkg::NODES; i++) begin
         link_mem[i] = (i == cllm_pkg::NODES - 1) ? 7'd0 : 7'(i + 1);
         value_mem[i] = 0;
         value_set[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed part: after reset, extremes, rings, error codes
      table_rows.push_back(row(cllm_pkg::OP_INSERT, 0, 0, 32'h7fffffff, 1, 1, 0, 0,
                               cllm_pkg::ST_OK));
      table_rows.push_back(row(cllm_pkg::OP_READ, 0, 1, 0, 1, 1, 32'h7fffffff, 2,
                               cllm_pkg::ST_OK));
      table_rows.push_back(row(cllm_pkg::OP_INSERT, 7'h7f, 1, 32'h80000000));
      table_rows.push_back(row(cllm_pkg::OP_FIND, 1, 0, 32'h80000000));
      table_rows.push_back(row(cllm_pkg::OP_FIND, 1, 0, 5, 1, 0, 0, 0,
                               cllm_pkg::ST_NOT_FOUND));
      table_rows.push_back(row(cllm_pkg::OP_INSERT, 0, 1, 32'hffffffff));
      table_rows.push_back(row(cllm_pkg::OP_INSERT, 0, 2, 32'h0));
      table_rows.push_back(row(cllm_pkg::OP_READ, 0, 2, 0));
      table_rows.push_back(row(cllm_pkg::OP_DELETE, 1, 0, 32'h0));
      table_rows.push_back(row(cllm_pkg::OP_DELETE, 1, 0, 12345, 1, 0, 0, 0,
                               cllm_pkg::ST_NOT_FOUND));
      table_rows.push_back(row(cllm_pkg::OP_MAKE_EMPTY, 0, 7'h7f, 32'hffffffff, 1));
      table_rows.push_back(row(cllm_pkg::OP_DELETE_LIST, 0, 7'h7f, 32'hffffffff, 1));
      table_rows.push_back(row(3'd6, 7'h7f, 7'h7f, 32'hffffffff, 1));
      table_rows.push_back(row(3'd7, 7'h7f, 7'h7f, 32'hffffffff, 1));
      table_rows.push_back(row(cllm_pkg::OP_INSERT, 0, 7'h7f, 32'h55aa55aa));
      table_rows.push_back(row(cllm_pkg::OP_FIND, 0, 0, 32'h55aa55aa));
      table_rows.push_back(row(cllm_pkg::OP_MAKE_EMPTY, 1, 0, 0));
      table_rows.push_back(row(cllm_pkg::OP_DELETE_LIST, 2, 0, 0));
      table_rows.push_back(row(cllm_pkg::OP_READ, 0, 1, 0));
      foreach (table_rows[i])
         if (reads_written_only(table_rows[i].c))
            issue(table_rows[i].c, table_rows[i].typed, table_rows[i].r, r);

      // random part: headers made by inserting a free node after itself
      sent = 0;
      next_mode = 0;
      next_drain = 250;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_mode) begin
            burst_mode = ($urandom_range(0, 2) == 0);
            next_mode = sent + 64;
         end
         if (sent >= next_drain) begin
            drain();
            next_drain = sent + 250;
         end
         k = $urandom_range(0, 99);
         c = '{cllm_pkg::OP_READ, 7'd0, 7'd0, 32'd0};
         if ((hdrs.size() == 0 || k < 6) && link_mem[0] != 0) begin
            c = '{cllm_pkg::OP_INSERT, 7'($urandom_range(0, 127)), link_mem[0], $urandom};
            issue(c, 0, r, r);
            sent++;
            if (r.st == cllm_pkg::ST_OK) hdrs.push_back(r.idx);
            if (hdrs.size() > 4) void'(hdrs.pop_front());
            continue;
         end
         if (hdrs.size() != 0 && k < 9) begin
            // fill the pool with 132 inserts, past the point where it reports full
            h = hdrs[$urandom_range(0, hdrs.size() - 1)];
            n = 0;
            while (n < 132) begin
               c = '{cllm_pkg::OP_INSERT, h, h, 32'($urandom_range(0, 15))};
               issue(c, 0, r, r);
               sent++;
               n++;
            end
            continue;
         end
         if (hdrs.size() == 0 || k < 24) begin
            c = '{3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)), $urandom};
         end else begin
            h = hdrs[$urandom_range(0, hdrs.size() - 1)];
            pick_from_list(h, ok, node, v);
            k = $urandom_range(0, 99);
            if (!ok || $urandom_range(0, 3) == 0)
               v = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 15));
            if (k < 35)
               c = '{cllm_pkg::OP_INSERT, h, ($urandom_range(0, 1) ? node : h),
                     ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 15)))};
            else if (k < 55) c = '{cllm_pkg::OP_FIND, h, node, v};
            else if (k < 78) c = '{cllm_pkg::OP_DELETE, h, node, v};
            else if (k < 90) c = '{cllm_pkg::OP_READ, h, node, v};
            else if (k < 95) c = '{cllm_pkg::OP_MAKE_EMPTY, h, node, v};
            else c = '{cllm_pkg::OP_DELETE_LIST, h, node, v};
         end
         if (!reads_written_only(c)) continue;
         issue(c, 0, r, r);
         sent++;
      end

      // wait out the last responses
      drain();
      repeat (300) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hw/rtl/cllm_pkg.sv
hw/rtl/cllm_dpath.sv
hw/rtl/cllm_ctrl.sv
hw/rtl/cursor_linked_list_manager_unit.sv
tb/tb.sv
